// ----- rtl/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types, codes and helpers for the two-pool bitmap slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  localparam int DEF_INODE_COUNT = 1024;
  localparam int DEF_DATA_COUNT  = 4096;

  localparam int FUNC_W = 2;
  localparam int NUM_W  = 16;
  localparam int CNT_W  = 13;
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the request word
    logic scan_start;  // rewind the scan pointer
    logic scan_run;    // stream one bitmap word per cycle
    logic rd_issue;    // read the word holding the request index
    logic eval_ft;     // apply free or test to the read word
    logic set_alloc;   // mark the found bit used
    logic load_out;    // move the result into the output register
  } bsa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              in_ok;
    logic              hit;
    logic              exhausted;
    logic              out_busy;
  } bsa_sts_t;

  // Position of the lowest clear bit; only meaningful if one exists.
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bsa_if.sv -----
// ----------------------------------------------------------------------------
// bsa_if
// Channel interfaces: request, response and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsa_req_if import bsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic              pool;
  logic [NUM_W-1:0]  number;
  modport source (output valid, func, pool, number, input ready);
  modport sink   (input valid, func, pool, number, output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic             in_range;
  logic [NUM_W-1:0] result_number;
  logic [CNT_W-1:0] free_count;
  modport source (output valid, found, in_range, result_number, free_count, input ready);
  modport sink   (input valid, found, in_range, result_number, free_count, output ready);
endinterface

interface bsa_cfg_if import bsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bsa_datapath.sv -----
// ----------------------------------------------------------------------------
// bsa_datapath
// Bitmap memories, scan pointer, free counters, request and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_datapath import bsa_pkg::*; #(
  parameter int INODE_COUNT = DEF_INODE_COUNT,
  parameter int DATA_COUNT  = DEF_DATA_COUNT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire bsa_cmd_t cmd,
  output bsa_sts_t      sts,
  bsa_req_if.sink       req,
  bsa_rsp_if.source     rsp,
  bsa_cfg_if.sink       cfg
);

  localparam int IW   = (INODE_COUNT + WORD_W - 1) / WORD_W;
  localparam int DW   = (DATA_COUNT + WORD_W - 1) / WORD_W;
  localparam int IAW  = (IW > 1) ? $clog2(IW) : 1;
  localparam int DAW  = (DW > 1) ? $clog2(DW) : 1;
  localparam int MAXW = (IW > DW) ? IW : DW;
  localparam int PW   = $clog2(MAXW + 1);
  localparam int IXW  = BIT_W + PW;
  localparam int ICW  = $clog2(INODE_COUNT + 1);
  localparam int DCW  = $clog2(DATA_COUNT + 1);
  localparam int IREM = INODE_COUNT % WORD_W;
  localparam int DREM = DATA_COUNT % WORD_W;
  localparam logic [WORD_W-1:0] ITAIL =
    (IREM == 0) ? '0 : ~((WORD_W'(1) << IREM) - WORD_W'(1));
  localparam logic [WORD_W-1:0] DTAIL =
    (DREM == 0) ? '0 : ~((WORD_W'(1) << DREM) - WORD_W'(1));

  // Request registers
  logic [FUNC_W-1:0] req_func;
  logic              req_pool;
  logic              req_ok;
  logic [IXW-1:0]    req_idx;
  logic [NUM_W-1:0]  data_base;

  logic [NUM_W:0]    diff;
  logic              ok_in;
  logic [IXW-1:0]    idx_in;

  assign diff   = {1'b0, req.number} - {1'b0, data_base};
  assign ok_in  = (req.func == FUNC_FREE || req.func == FUNC_TEST) &&
                  (req.pool ? (!diff[NUM_W] && diff[NUM_W-1:0] < NUM_W'(DATA_COUNT))
                            : (req.number < NUM_W'(INODE_COUNT)));
  assign idx_in = req.pool ? diff[IXW-1:0] : req.number[IXW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func <= req.func;
      req_pool <= req.pool;
      req_ok   <= ok_in;
      req_idx  <= idx_in;
    end
  end

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_base <= '0;
    end else if (cfg.valid) begin
      data_base <= cfg.data;
    end
  end

  // Scan pointer and read issue
  logic [PW-1:0]     ptr;
  logic [PW-1:0]     dptr;
  logic              dv;
  logic [PW-1:0]     words_sel;
  logic              scan_rd;
  logic              rd_go;
  logic [PW-1:0]     rd_addr;

  assign words_sel = req_pool ? PW'(DW) : PW'(IW);
  assign scan_rd   = cmd.scan_run && (ptr < words_sel);
  assign rd_go     = cmd.rd_issue || scan_rd;
  assign rd_addr   = cmd.rd_issue ? req_idx[IXW-1:BIT_W] : ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      dv  <= 1'b0;
    end else if (cmd.scan_start) begin
      ptr <= '0;
      dv  <= 1'b0;
    end else if (cmd.scan_run) begin
      dv <= scan_rd;
      if (scan_rd) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_rd) begin
      dptr <= ptr;
    end
  end

  // Bitmap memories; a row never written reads as all free
  logic [WORD_W-1:0] imem [IW];
  logic [WORD_W-1:0] dmem [DW];
  logic [IW-1:0]     ivld;
  logic [DW-1:0]     dvld;
  logic [WORD_W-1:0] i_rdata;
  logic [WORD_W-1:0] d_rdata;
  logic              i_rvld;
  logic              d_rvld;
  logic [WORD_W-1:0] rword;

  logic              wr_en;
  logic [PW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (rd_go && !req_pool) begin
      i_rdata <= imem[rd_addr[IAW-1:0]];
      i_rvld  <= ivld[rd_addr[IAW-1:0]];
    end
    if (rd_go && req_pool) begin
      d_rdata <= dmem[rd_addr[DAW-1:0]];
      d_rvld  <= dvld[rd_addr[DAW-1:0]];
    end
    if (wr_en && !req_pool) begin
      imem[wr_addr[IAW-1:0]] <= wr_data;
    end
    if (wr_en && req_pool) begin
      dmem[wr_addr[DAW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ivld <= '0;
      dvld <= '0;
    end else if (wr_en) begin
      if (req_pool) begin
        dvld[wr_addr[DAW-1:0]] <= 1'b1;
      end else begin
        ivld[wr_addr[IAW-1:0]] <= 1'b1;
      end
    end
  end

  assign rword = req_pool ? (d_rvld ? d_rdata : '0) : (i_rvld ? i_rdata : '0);

  // Scan evaluation: bits past the pool end count as used
  logic              last_word;
  logic [WORD_W-1:0] word_m;
  logic [BIT_W-1:0]  zpos;
  logic [IXW-1:0]    alloc_idx;

  assign last_word = (dptr == words_sel - 1'b1);
  assign word_m    = rword | (last_word ? (req_pool ? DTAIL : ITAIL) : '0);
  assign zpos      = first_zero(word_m);
  assign alloc_idx = {dptr, zpos};

  assign wr_en   = cmd.set_alloc || (cmd.eval_ft && req_func == FUNC_FREE);
  assign wr_addr = cmd.set_alloc ? dptr : req_idx[IXW-1:BIT_W];
  assign wr_data = cmd.set_alloc ? (rword | (WORD_W'(1) << zpos))
                                 : (rword & ~(WORD_W'(1) << req_idx[BIT_W-1:0]));

  // Free counters
  logic [ICW-1:0] icnt;
  logic [DCW-1:0] dcnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      icnt <= ICW'(INODE_COUNT);
      dcnt <= DCW'(DATA_COUNT);
    end else if (cmd.set_alloc) begin
      if (req_pool && dcnt != '0) begin
        dcnt <= dcnt - 1'b1;
      end else if (!req_pool && icnt != '0) begin
        icnt <= icnt - 1'b1;
      end
    end else if (cmd.eval_ft && req_func == FUNC_FREE) begin
      if (req_pool && dcnt < DCW'(DATA_COUNT)) begin
        dcnt <= dcnt + 1'b1;
      end else if (!req_pool && icnt < ICW'(INODE_COUNT)) begin
        icnt <= icnt + 1'b1;
      end
    end
  end

  // Result staging
  logic             res_found;
  logic             res_inr;
  logic [NUM_W-1:0] res_num;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_found <= 1'b0;
      res_inr   <= 1'b0;
      res_num   <= '0;
    end else if (cmd.set_alloc) begin
      res_found <= 1'b1;
      res_num   <= req_pool ? (NUM_W'(alloc_idx) + data_base) : NUM_W'(alloc_idx);
    end else if (cmd.eval_ft) begin
      res_inr   <= 1'b1;
      res_found <= (req_func == FUNC_TEST) && rword[req_idx[BIT_W-1:0]];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.found         <= res_found;
      rsp.in_range      <= res_inr;
      rsp.result_number <= res_num;
      rsp.free_count    <= req_pool ? CNT_W'(dcnt) : CNT_W'(icnt);
    end
  end

  assign sts.func      = req_func;
  assign sts.in_ok     = req_ok;
  assign sts.hit       = dv && !(&word_m);
  assign sts.exhausted = dv && (&word_m) && last_word;
  assign sts.out_busy  = rsp.valid && !rsp.ready;

endmodule

`default_nettype wire

// ----- rtl/bsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsa_ctrl
// Request sequencer: dispatch, word scan, free/test update, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl import bsa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire bsa_sts_t sts,
  output bsa_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.func == FUNC_ALLOC) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (sts.in_ok) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_EVAL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.hit) begin
          cmd.set_alloc = 1'b1;
          state_next    = S_DONE;
        end else if (sts.exhausted) begin
          state_next = S_DONE;
        end
      end
      S_EVAL: begin
        cmd.eval_ft = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_no_hit_and_miss: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !(sts.hit && sts.exhausted))
    else $error("scan reports hit and exhausted together");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !sts.out_busy)
    else $error("result loaded over a waiting word");

  a_capture_dispatch: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_DISP))
    else $error("captured request not dispatched");

endmodule

`default_nettype wire

// ----- rtl/bitmap_slot_allocator_top.sv -----
// Free/test: request registers, bitmap read, result staging, output register (no read
//   when out of pool or spare code); allocate scans up to WORDS = ceil(size / 64) words.
// Throughput: one request at a time, the next accepted in the cycle after the result
//   loads; the scan reads one word/cycle.
// Reset (rst, synchronous): both bitmaps read as all free at once through per-row
//   valid bits, free counts load the pool sizes, data_base clears to 0; no port ready.
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top
// Two-pool first-fit bitmap allocator: allocate, free and test on an inode
// pool and a data block pool, each result carrying the pool's free count.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator_top import bsa_pkg::*; #(
  parameter int INODE_COUNT = DEF_INODE_COUNT,
  parameter int DATA_COUNT  = DEF_DATA_COUNT
) (
  input  wire logic clk,
  input  wire logic rst,
  bsa_cfg_if.sink   cfg,
  bsa_req_if.sink   req,
  bsa_rsp_if.source rsp
);

  // Command and status between the sequencer and the datapath.
  bsa_cmd_t cmd;
  bsa_sts_t sts;
  logic     req_ready;

  // Accept a request word only while the sequencer is idle; the finished
  // result sits in the output register, so a new word may enter while the
  // previous result still waits for its sink.
  assign req.ready = req_ready;

  // Sequencer: capture, dispatch by operation, run the word scan, apply
  // free/test, hand the result to the output register.
  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: the two bitmap memories, scan pointer, counters, base register
  // and the output register.
  bsa_datapath #(
    .INODE_COUNT (INODE_COUNT),
    .DATA_COUNT  (DATA_COUNT)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

endmodule

`default_nettype wire

// ----- bench/bitmap_slot_allocator_top_test.sv -----
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top_test
// Self-checking bench for the two-pool first-fit allocator. A shadow copy of
// both used-maps, both free counts and the data base predicts every reply
// word. Directed words and random phases under several data bases run against
// bursty requests and a stalling response side; block numbers wrapping under a
// high base run with both turned off.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator_top_test import bsa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INODE_COUNT      = DEF_INODE_COUNT;
  localparam int DATA_COUNT       = DEF_DATA_COUNT;
  localparam int CLK_PERIOD       = 10;
  localparam int CYCLE_LIMIT      = 2_000_000;
  localparam int HOLD_CYCLES      = 300;
  // Longest allocate scans 64 words; leave margin.
  localparam int DRAIN_CYCLES     = 100;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int PHASE_WORDS      = 140;
  localparam int PHASES           = 4;
  localparam int WRAP_ALLOCS      = 24;

  localparam logic POOL_INODE = 1'b0;
  localparam logic POOL_DATA  = 1'b1;
  // The one func code the block leaves unused.
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              pool;
    logic [NUM_W-1:0]  number;
  } slot_req_t;

  typedef struct packed {
    logic             found;
    logic             in_range;
    logic [NUM_W-1:0] result_number;
    logic [CNT_W-1:0] free_count;
  } slot_reply_t;

  logic clk;
  logic rst;

  bsa_cfg_if cfg_ch ();
  bsa_req_if req_ch ();
  bsa_rsp_if rsp_ch ();

  bitmap_slot_allocator_top #(
    .INODE_COUNT (INODE_COUNT),
    .DATA_COUNT  (DATA_COUNT)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow state: which slots are taken, the free counts as the block keeps
  // them (these may run ahead of the true free total), and the data base.
  bit               inode_taken [INODE_COUNT];
  bit               block_taken [DATA_COUNT];
  int               inode_left;
  int               block_left;
  logic [NUM_W-1:0] block_base;

  slot_reply_t replies_due [$];
  int          mismatches;
  int          cycle_count;

  // Sender pacing and receiver control.
  int burst_left;
  bit req_dropped;
  bit fast_mode;
  bit hold_request;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor: apply one request word to the shadow state and return the
  // reply word the block must produce for it.
  // --------------------------------------------------------------------------
  function automatic slot_reply_t predict_slot_op(input slot_req_t word);
    slot_reply_t reply;
    int          size;
    int          count;
    int          idx;
    bit          in_pool;
    bit          hit;
    reply   = '0;
    in_pool = 1'b0;
    idx     = 0;
    size    = (word.pool == POOL_DATA) ? DATA_COUNT : INODE_COUNT;
    count   = (word.pool == POOL_DATA) ? block_left : inode_left;

    // Free and test address a slot; data numbers are absolute, no wrap.
    if (word.func == FUNC_FREE || word.func == FUNC_TEST) begin
      if (word.pool == POOL_DATA) begin
        if (word.number >= block_base &&
            int'(word.number) - int'(block_base) < DATA_COUNT) begin
          idx     = int'(word.number) - int'(block_base);
          in_pool = 1'b1;
        end
      end else if (int'(word.number) < INODE_COUNT) begin
        idx     = int'(word.number);
        in_pool = 1'b1;
      end
    end

    case (word.func)
      FUNC_ALLOC: begin
        // First fit: walk up to the lowest free slot.
        hit = 1'b0;
        while (!hit && idx < size) begin
          if (word.pool == POOL_DATA) hit = !block_taken[idx];
          else                        hit = !inode_taken[idx];
          if (!hit) idx++;
        end
        if (hit) begin
          if (word.pool == POOL_DATA) block_taken[idx] = 1'b1;
          else                        inode_taken[idx] = 1'b1;
          if (count > 0) count--;
          reply.found = 1'b1;
          // Data numbers wrap at 16 bits when the base is high.
          reply.result_number = (word.pool == POOL_DATA) ?
                                NUM_W'(idx + int'(block_base)) : NUM_W'(idx);
        end
      end
      FUNC_FREE: begin
        if (in_pool) begin
          reply.in_range = 1'b1;
          if (word.pool == POOL_DATA) block_taken[idx] = 1'b0;
          else                        inode_taken[idx] = 1'b0;
          // Freeing a free slot still bumps the count, up to the pool size.
          if (count < size) count++;
        end
      end
      FUNC_TEST: begin
        if (in_pool) begin
          reply.in_range = 1'b1;
          reply.found = (word.pool == POOL_DATA) ? block_taken[idx] : inode_taken[idx];
        end
      end
      default: begin
        // Spare code: touch nothing, just report the count.
      end
    endcase

    if (word.pool == POOL_DATA) block_left = count;
    else                        inode_left = count;
    reply.free_count = CNT_W'(count);
    return reply;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one word, hold it until accepted, then record its expected reply.
  // Words go out in bursts; outside fast mode a gap opens whenever a burst is used up.
  task automatic send_word(input slot_req_t word, output slot_reply_t reply);
    int gap;
    if (!fast_mode && burst_left == 0) begin
      if (!req_dropped) req_ch.valid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      // About one burst in eight runs long with no idling at all.
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
    end else if (req_dropped) begin
      // Valid was lowered in this step already; never raise it in the same one.
      @(posedge clk);
    end
    req_dropped   = 1'b0;
    req_ch.valid  <= 1'b1;
    req_ch.func   <= word.func;
    req_ch.pool   <= word.pool;
    req_ch.number <= word.number;
    do @(posedge clk); while (!req_ch.ready);
    reply = predict_slot_op(word);
    replies_due.push_back(reply);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic issue(input logic [FUNC_W-1:0] func, input logic pool,
                       input logic [NUM_W-1:0] number);
    slot_reply_t ignored;
    send_word('{func: func, pool: pool, number: number}, ignored);
  endtask

  // Stop offering and wait until every reply word is back.
  task automatic drain_replies();
    if (!req_dropped) begin
      req_ch.valid <= 1'b0;
      req_dropped  = 1'b1;
    end
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Write data_base while the block is idle and mirror it in the shadow.
  task automatic write_data_base(input logic [NUM_W-1:0] base);
    drain_replies();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= base;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    block_base = base;
  endtask

  // Mostly slots near the bottom, where first fit puts things, plus whole-pool
  // picks, pool edges and raw 16-bit numbers.
  function automatic slot_req_t random_request();
    slot_req_t word;
    int        roll;
    int        size;
    int        idx;
    roll = $urandom_range(0, 99);
    if (roll < 35)      word.func = FUNC_ALLOC;
    else if (roll < 65) word.func = FUNC_FREE;
    else if (roll < 92) word.func = FUNC_TEST;
    else                word.func = FUNC_SPARE;
    word.pool = 1'($urandom_range(0, 1));
    size = (word.pool == POOL_DATA) ? DATA_COUNT : INODE_COUNT;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      idx = $urandom_range(0, 63);
    end else if (roll < 75) begin
      idx = $urandom_range(0, size - 1);
    end else if (roll < 85) begin
      case ($urandom_range(0, 3))
        0:       idx = size - 1;
        1:       idx = size;
        2:       idx = -1;
        default: idx = 0;
      endcase
    end else begin
      word.number = NUM_W'($urandom_range(0, 65535));
      return word;
    end
    word.number = (word.pool == POOL_DATA) ? NUM_W'(int'(block_base) + idx) : NUM_W'(idx);
    return word;
  endfunction

  // --------------------------------------------------------------------------
  // Response side: stall on a changing pattern. A hold request from a test
  // turns into a long stretch of ready low, counted here.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int mode;
    int mode_left;
    int tick;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (fast_mode) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          2:       rsp_ch.ready <= (tick % 4 == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare each reply word with the oldest expectation, field by field.
  slot_reply_t seen_reply;
  slot_reply_t due_reply;

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen_reply = '{found: rsp_ch.found, in_range: rsp_ch.in_range,
                     result_number: rsp_ch.result_number, free_count: rsp_ch.free_count};
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) begin
          $display("cycle %0d: reply word with none due: found=%0b in_range=%0b number=%0d free=%0d",
                   cycle_count, seen_reply.found, seen_reply.in_range,
                   seen_reply.result_number, seen_reply.free_count);
        end
      end else begin
        due_reply = replies_due.pop_front();
        if (seen_reply.found !== due_reply.found ||
            seen_reply.in_range !== due_reply.in_range ||
            seen_reply.result_number !== due_reply.result_number ||
            seen_reply.free_count !== due_reply.free_count) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES) begin
            $display("cycle %0d: reply mismatch: expected found=%0b in_range=%0b number=%0d free=%0d",
                     cycle_count, due_reply.found, due_reply.in_range,
                     due_reply.result_number, due_reply.free_count);
            $display("                           got found=%0b in_range=%0b number=%0d free=%0d",
                     seen_reply.found, seen_reply.in_range,
                     seen_reply.result_number, seen_reply.free_count);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Inode pool from reset: first fit, test edges, double free, spare code.
  task automatic test_inode_basics();
    issue(FUNC_TEST,  POOL_INODE, 16'd0);               // fresh pool reads free
    issue(FUNC_ALLOC, POOL_INODE, 16'hFFFF);            // number ignored, takes 0
    issue(FUNC_ALLOC, POOL_INODE, 16'd0);               // takes 1
    issue(FUNC_TEST,  POOL_INODE, 16'd1);
    issue(FUNC_TEST,  POOL_INODE, NUM_W'(INODE_COUNT - 1));
    issue(FUNC_TEST,  POOL_INODE, NUM_W'(INODE_COUNT)); // just past the pool
    issue(FUNC_TEST,  POOL_INODE, 16'hFFFF);
    issue(FUNC_FREE,  POOL_INODE, 16'd0);
    // Free an already free slot: count climbs back to the pool size.
    issue(FUNC_FREE,  POOL_INODE, 16'd0);
    // Count is at the pool size now, so this one must saturate.
    issue(FUNC_FREE,  POOL_INODE, 16'd5);
    issue(FUNC_FREE,  POOL_INODE, NUM_W'(INODE_COUNT));
    issue(FUNC_SPARE, POOL_INODE, 16'd1);
    issue(FUNC_SPARE, POOL_DATA,  16'hFFFF);
  endtask

  // Data pool with the reset base, then an offset base and its edges.
  task automatic test_data_basics();
    issue(FUNC_ALLOC, POOL_DATA, 16'd0);                // base 0 from reset
    write_data_base(16'd100);
    issue(FUNC_TEST,  POOL_DATA, 16'd100);              // index 0, taken above
    issue(FUNC_TEST,  POOL_DATA, 16'd99);               // below base
    issue(FUNC_TEST,  POOL_DATA, NUM_W'(100 + DATA_COUNT - 1));
    issue(FUNC_TEST,  POOL_DATA, NUM_W'(100 + DATA_COUNT));
    issue(FUNC_FREE,  POOL_DATA, 16'd100);
    issue(FUNC_ALLOC, POOL_DATA, 16'd0);                // comes back as 100
    issue(FUNC_FREE,  POOL_DATA, 16'hFFFF);
  endtask

  // Random words in phases under different bases. The first phase holds the
  // response side off while words keep coming, so the block backs up; the
  // third pauses the sender until every reply is in.
  task automatic test_random_phases();
    slot_reply_t      ignored;
    logic [NUM_W-1:0] base;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       base = 16'd61440;
        1:       base = 16'd0;
        2:       base = NUM_W'($urandom_range(0, 61440));
        default: base = 16'd1243;
      endcase
      write_data_base(base);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i == PHASE_WORDS / 2 && phase == 0) hold_request = 1'b1;
        if (i == PHASE_WORDS / 2 && phase == 2) drain_replies();
        send_word(random_request(), ignored);
      end
    end
  endtask

  // Put the data base near the top so allocated block numbers run past
  // 16'hFFFF and wrap, probe the pool edges there, and reuse a freed slot.
  task automatic test_high_base_wrap();
    write_data_base(16'hFFF0);
    fast_mode = 1'b1;
    for (int i = 0; i < WRAP_ALLOCS; i++) begin
      issue(FUNC_ALLOC, POOL_DATA, 16'd0);
    end
    issue(FUNC_TEST,  POOL_DATA, 16'hFFF0);
    issue(FUNC_TEST,  POOL_DATA, 16'hFFFF);
    issue(FUNC_TEST,  POOL_DATA, 16'h0000);             // below base, out of pool
    issue(FUNC_TEST,  POOL_DATA, 16'hFFEF);
    issue(FUNC_FREE,  POOL_DATA, 16'hFFF5);
    issue(FUNC_ALLOC, POOL_DATA, 16'd0);
    issue(FUNC_ALLOC, POOL_DATA, 16'd0);
    issue(FUNC_ALLOC, POOL_INODE, 16'd0);
    issue(FUNC_FREE,  POOL_INODE, 16'd512);
    issue(FUNC_TEST,  POOL_INODE, 16'd512);
    issue(FUNC_ALLOC, POOL_INODE, 16'd0);
    issue(FUNC_SPARE, POOL_DATA, 16'd0);
    fast_mode = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Run
  // --------------------------------------------------------------------------
  initial begin
    rst           <= 1'b1;
    req_ch.valid  <= 1'b0;
    req_ch.func   <= FUNC_ALLOC;
    req_ch.pool   <= POOL_INODE;
    req_ch.number <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    // Shadow starts in the reset state: everything free, base zero.
    inode_left   = INODE_COUNT;
    block_left   = DATA_COUNT;
    block_base   = '0;
    mismatches   = 0;
    burst_left   = 0;
    req_dropped  = 1'b1;
    fast_mode    = 1'b0;
    hold_request = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_inode_basics();
    test_data_basics();
    test_random_phases();
    test_high_base_wrap();

    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
